/* src/signed_decimal_line_parser_unit_defines.svh */
// Assertion macros shared by the signed decimal line parser RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef SIGNED_DECIMAL_LINE_PARSER_UNIT_DEFINES_SVH
`define SIGNED_DECIMAL_LINE_PARSER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset
`define SDLP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sdlp assertion failed");
// Next-cycle implication, checked outside reset
`define SDLP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sdlp assertion failed");
`else
`define SDLP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SDLP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* src/sdlp_pkg.sv */
// Types and constants of the signed decimal line parser.
// No dependencies; used by sdlp_core and the top level.
package sdlp_pkg;

    // Parse phase of the line being collected
    typedef enum logic [1:0] {
        PH_NONE   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_TRAIL  = 2'd3
    } t_phase;

    // Status carried by each result
    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_NO_DIGITS = 2'd1,
        ST_TRAIL     = 2'd2
    } t_status;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int MAG_W      = 15;
    localparam int IDLE_W     = 16;
    localparam int VAL_W      = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LIMIT = 4'd1;

    localparam logic [IDLE_W-1:0] TIMEOUT_RST = 16'd200;
    localparam logic [MAG_W-1:0]  LIMIT_RST   = 15'd255;
    localparam logic [MAG_W-1:0]  MAG_MAX     = 15'h7FFF;
    localparam logic [IDLE_W-1:0] IDLE_MAX    = 16'hFFFF;

    // Character codes
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Line state apart from the character count
    typedef struct packed {
        t_phase            phase;
        logic              neg;
        logic [MAG_W-1:0]  mag;
    } t_line;

    // Result of one item
    typedef struct packed {
        logic              emit;
        t_status           status;
        logic [VAL_W-1:0]  value;
    } t_result;

endpackage

/* src/signed_decimal_line_parser_unit.sv */
// Signed decimal line parser: one received byte or millisecond tick per
// transfer on the input channel, one status and clamped value per completed
// line on the output channel. The unit takes one item every clock cycle while
// its input is ready; its result is held in a single output register and is
// presented in the cycle after the input transfer. The input is ready whenever
// that register is empty or is being read in the same cycle, so throughput is
// set by the output register alone. Configuration writes are always ready and
// take effect on the next cycle.
// Depends on sdlp_pkg, sdlp_core and signed_decimal_line_parser_unit_defines.svh.
`include "signed_decimal_line_parser_unit_defines.svh"

module signed_decimal_line_parser_unit #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Item input
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_mode,
    input  logic [7:0]                        i_rx_byte,
    // Result output
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_line_status,
    output logic signed [sdlp_pkg::VAL_W-1:0] o_pwm_value,
    // Configuration write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sdlp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sdlp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sdlp_pkg::*;

    localparam int CNT_W = (LINE_CAPACITY > 2) ? $clog2(LINE_CAPACITY) : 1;

    logic [CNT_W-1:0]   r_count;
    t_line              r_line;
    logic [IDLE_W-1:0]  r_idle;
    logic [IDLE_W-1:0]  r_timeout;
    logic [MAG_W-1:0]   r_limit;
    logic               r_out_valid;
    t_status            r_out_status;
    logic [VAL_W-1:0]   r_out_value;

    logic [CNT_W-1:0]   n_count;
    t_line              n_line;
    logic [IDLE_W-1:0]  n_idle;
    t_result            n_result;
    logic               in_xfer;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && o_in_ready;

    sdlp_core #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .CNT_W         (CNT_W)
    ) u_core (
        .i_mode    (i_mode),
        .i_rx_byte (i_rx_byte),
        .i_count   (r_count),
        .i_line    (r_line),
        .i_idle    (r_idle),
        .i_timeout (r_timeout),
        .i_limit   (r_limit),
        .o_count   (n_count),
        .o_line    (n_line),
        .o_idle    (n_idle),
        .o_result  (n_result)
    );

    // Hold line state; advance it on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_line  <= '{phase: PH_NONE, neg: 1'b0, mag: '0};
            r_idle  <= '0;
        end else if (in_xfer) begin
            r_count <= n_count;
            r_line  <= n_line;
            r_idle  <= n_idle;
        end
    end

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_limit   <= LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TIMEOUT_MS:  r_timeout <= i_cfg_data;
                CFG_VALUE_LIMIT: r_limit   <= i_cfg_data[MAG_W-1:0];
                default: ;
            endcase
        end
    end

    // Output register: load on an emitting transfer, release on an output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= n_result.emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && n_result.emit) begin
            r_out_status <= n_result.status;
            r_out_value  <= n_result.value;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_line_status = r_out_status;
    assign o_pwm_value   = r_out_value;

    // Checks
    `SDLP_ASSERT_IMP(a_no_take_when_stalled, i_clk, i_rst_n,
        r_out_valid && !i_out_ready, !o_in_ready)
    `SDLP_ASSERT_IMP(a_zero_unless_valid, i_clk, i_rst_n,
        o_out_valid && (o_line_status != ST_VALID), o_pwm_value == '0)
    `SDLP_ASSERT_IMP(a_value_within_limit, i_clk, i_rst_n,
        o_out_valid && (o_line_status == ST_VALID),
        (o_pwm_value <= $signed({1'b0, r_limit})) && (o_pwm_value >= -$signed({1'b0, r_limit})))
    `SDLP_ASSERT_IMP(a_count_bounded, i_clk, i_rst_n,
        1'b1, r_count <= CNT_W'(LINE_CAPACITY - 1))
    `SDLP_ASSERT_NXT(a_newline_clears, i_clk, i_rst_n,
        in_xfer && !i_mode && (i_rx_byte == CH_NL), r_count == '0)

endmodule

/* src/sdlp_core.sv */
// Next-state and result logic of the line parser for one item.
// Depends on sdlp_pkg; instanced by signed_decimal_line_parser_unit.
module sdlp_core #(
    parameter int LINE_CAPACITY = 64,
    parameter int CNT_W         = 6
) (
    input  logic                           i_mode,
    input  logic [7:0]                     i_rx_byte,
    input  logic [CNT_W-1:0]               i_count,
    input  sdlp_pkg::t_line                i_line,
    input  logic [sdlp_pkg::IDLE_W-1:0]    i_idle,
    input  logic [sdlp_pkg::IDLE_W-1:0]    i_timeout,
    input  logic [sdlp_pkg::MAG_W-1:0]     i_limit,
    output logic [CNT_W-1:0]               o_count,
    output sdlp_pkg::t_line                o_line,
    output logic [sdlp_pkg::IDLE_W-1:0]    o_idle,
    output sdlp_pkg::t_result              o_result
);
    import sdlp_pkg::*;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LINE_CAPACITY - 1);

    logic                 is_digit;
    logic                 is_sign;
    logic                 is_blank;
    logic                 empty;
    logic [MAG_W+3:0]     mag_acc;
    logic [MAG_W-1:0]     mag_sat;
    logic [MAG_W-1:0]     mag_clamp;
    logic [IDLE_W-1:0]    idle_inc;
    t_line                line_clr;

    // Classify the byte
    assign is_digit = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign is_sign  = (i_rx_byte == CH_PLUS) || (i_rx_byte == CH_MINUS);
    assign is_blank = (i_rx_byte == CH_SPACE) || (i_rx_byte == CH_TAB);
    assign empty    = (i_count == '0);

    // Times-ten accumulate, saturating at the 15-bit maximum
    assign mag_acc = {i_line.mag, 3'b000} + {2'b00, i_line.mag, 1'b0}
                   + {{MAG_W{1'b0}}, (i_rx_byte[3:0] - CH_ZERO[3:0])} ;
    assign mag_sat = (mag_acc > {4'b0000, MAG_MAX}) ? MAG_MAX : mag_acc[MAG_W-1:0];

    // Clamp for the output value
    assign mag_clamp = (i_line.mag > i_limit) ? i_limit : i_line.mag;

    assign idle_inc = (i_idle != IDLE_MAX) ? i_idle + 1'b1 : i_idle;

    assign line_clr = '{phase: PH_NONE, neg: 1'b0, mag: '0};

    always_comb begin
        o_count  = i_count;
        o_line   = i_line;
        o_idle   = '0;
        o_result = '{emit: 1'b0, status: ST_VALID, value: '0};
        if (i_mode) begin
            // Tick: count idle time, drop a stale partial line
            o_idle = idle_inc;
            if (!empty && (idle_inc > i_timeout)) begin
                o_count = '0;
                o_line  = line_clr;
                o_idle  = '0;
            end
        end else if (i_rx_byte == CH_NL) begin
            // Newline: report a non-empty line, then clear
            if (!empty) begin
                o_result.emit = 1'b1;
                case (i_line.phase)
                    PH_DIGITS: begin
                        o_result.status = ST_VALID;
                        o_result.value  = i_line.neg ? (VAL_W'(0) - {1'b0, mag_clamp})
                                                     : {1'b0, mag_clamp};
                    end
                    PH_TRAIL: o_result.status = ST_TRAIL;
                    default:  o_result.status = ST_NO_DIGITS;
                endcase
            end
            o_count = '0;
            o_line  = line_clr;
        end else if (i_rx_byte == CH_CR) begin
            // Carriage return: ignore
        end else if (i_count >= CNT_FULL) begin
            // Full line: drop it
            o_count = '0;
            o_line  = line_clr;
        end else if (is_digit) begin
            o_count = i_count + 1'b1;
            if (!(i_line.phase == PH_NONE && !empty) && (i_line.phase != PH_TRAIL)) begin
                o_line.mag   = mag_sat;
                o_line.phase = PH_DIGITS;
            end
        end else if (is_sign) begin
            o_count = i_count + 1'b1;
            if (i_line.phase == PH_NONE && empty) begin
                o_line.phase = PH_SIGN;
                o_line.neg   = (i_rx_byte == CH_MINUS);
            end else if (i_line.phase == PH_SIGN) begin
                o_line.phase = PH_NONE;
            end else if (i_line.phase == PH_DIGITS) begin
                o_line.phase = PH_TRAIL;
            end
        end else if (is_blank) begin
            // Blank: skip
        end else if (!empty) begin
            // Any other byte spoils the line
            o_count = '0;
            o_line  = line_clr;
        end
    end

endmodule
